[rtl/core/bpls_pkg.sv]
`timescale 1ns / 1ps

package bpls_pkg;

	// Status codes in check priority order, but DEGENERATE beats OUTSIDE.
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NEG_FORCE   = 3'd1,
		ST_NORMAL      = 3'd2,
		ST_TANGENT     = 3'd3,
		ST_ORTHO       = 3'd4,
		ST_OUTSIDE     = 3'd5,
		ST_DEGENERATE  = 3'd6
	} status_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_X_MIN  = 3'd0,
		REG_X_MAX  = 3'd1,
		REG_Y_MIN  = 3'd2,
		REG_Y_MAX  = 3'd3,
		REG_SLACK  = 3'd4,
		REG_TOL    = 3'd5
	} reg_index_t;

	// One quotient bit per divider stage; quotients lie in [0, 2^30].
	localparam int DIV_STEPS = 31;
	localparam int FRAC_BITS = 30;

	// Payload that rides alongside the fraction dividers.
	typedef struct packed {
		status_t            status;
		logic signed [31:0] ft;
		logic signed [31:0] fn;
	} div_side_t;

	// Shift right by 28, round to nearest, ties away from zero.
	function automatic logic signed [63:0] round28(input logic signed [63:0] v);
		logic signed [63:0] t;
		begin
			t = v + 64'sd134217728 - 64'(v[63]);
			return t >>> 28;
		end
	endfunction

	// Shift right by 30, round to nearest, ties away from zero.
	function automatic logic signed [63:0] round30(input logic signed [63:0] v);
		logic signed [63:0] t;
		begin
			t = v + 64'sd536870912 - 64'(v[63]);
			return t >>> 30;
		end
	endfunction

	// Saturate to 32 bit signed.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		begin
			if (v > 64'sd2147483647) begin
				return 32'sh7FFFFFFF;
			end else if (v < -64'sd2147483648) begin
				return 32'sh80000000;
			end
			return v[31:0];
		end
	endfunction

endpackage

[rtl/core/bpls_div_pipe.sv]
`timescale 1ns / 1ps

// Two restoring dividers side by side, one quotient bit per stage.
// Each numerator must satisfy num < span * 2^31 so the quotient fits 31 bits.
module bpls_div_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [63:0]          in_num_x,
	input  logic [63:0]          in_num_y,
	input  bpls_pkg::div_side_t  in_side,
	input  logic [31:0]          span_x,
	input  logic [31:0]          span_y,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [30:0]          out_quo_x,
	output logic [30:0]          out_quo_y,
	output bpls_pkg::div_side_t  out_side
);

	localparam int N = bpls_pkg::DIV_STEPS;

	logic [N-1:0]        vld_sd;
	logic [N-1:0]        en;
	logic [31:0]         rx_sd [N];
	logic [31:0]         ry_sd [N];
	logic [30:0]         lx_sd [N];
	logic [30:0]         ly_sd [N];
	logic [30:0]         qx_sd [N];
	logic [30:0]         qy_sd [N];
	bpls_pkg::div_side_t side_sd [N];

	always_comb begin
		en[N-1] = !vld_sd[N-1] || out_ready;
		for (int j = N - 2; j >= 0; j--) begin
			en[j] = !vld_sd[j] || en[j+1];
		end
	end

	assign in_ready = en[0];

	for (genvar j = 0; j < N; j++) begin : g_step
		logic                pv;
		logic [31:0]         prx, pry;
		logic [30:0]         plx, ply, pqx, pqy;
		bpls_pkg::div_side_t pside;
		logic [32:0]         tx, ty, dxs, dys;
		logic                gx, gy;

		if (j == 0) begin : g_first
			assign pv    = in_valid;
			assign prx   = in_num_x[62:31];
			assign pry   = in_num_y[62:31];
			assign plx   = in_num_x[30:0];
			assign ply   = in_num_y[30:0];
			assign pqx   = '0;
			assign pqy   = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = vld_sd[j-1];
			assign prx   = rx_sd[j-1];
			assign pry   = ry_sd[j-1];
			assign plx   = lx_sd[j-1];
			assign ply   = ly_sd[j-1];
			assign pqx   = qx_sd[j-1];
			assign pqy   = qy_sd[j-1];
			assign pside = side_sd[j-1];
		end

		always_comb begin
			tx  = {prx, plx[30]};
			ty  = {pry, ply[30]};
			gx  = tx >= {1'b0, span_x};
			gy  = ty >= {1'b0, span_y};
			dxs = gx ? (tx - {1'b0, span_x}) : tx;
			dys = gy ? (ty - {1'b0, span_y}) : ty;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[j] <= 1'b0;
			end else if (en[j]) begin
				vld_sd[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rx_sd[j]   <= dxs[31:0];
				ry_sd[j]   <= dys[31:0];
				lx_sd[j]   <= {plx[29:0], 1'b0};
				ly_sd[j]   <= {ply[29:0], 1'b0};
				qx_sd[j]   <= {pqx[29:0], gx};
				qy_sd[j]   <= {pqy[29:0], gy};
				side_sd[j] <= pside;
			end
		end
	end

	assign out_valid = vld_sd[N-1];
	assign out_quo_x = qx_sd[N-1];
	assign out_quo_y = qy_sd[N-1];
	assign out_side  = side_sd[N-1];

endmodule

[rtl/core/bilinear_point_load_scatter.sv]
`timescale 1ns / 1ps

// Pipeline: 40 register stages.
// Throughput: one item per cycle while the output is not stalled; a stage holds its item
// while the stage after it is full and cannot move on.
// Depth is set by the two fraction dividers, which retire one quotient bit per stage (31 stages).
// Reset clears every valid bit and restores the configuration registers to their defaults;
// data registers are not reset.
module bilinear_point_load_scatter (
	input  logic          clk,
	input  logic          arst_n,
	// Configuration write channel.
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	// Contact event items.
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// From bit 0: force_magnitude[31:0], normal_x[15:0], normal_y[15:0], tangent_x[15:0],
	// tangent_y[15:0], point_x[31:0], point_y[31:0].
	input  logic [159:0]  s_axis_tdata,
	// Result items.
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// From bit 0: total_tangential, total_normal, corner0_tangential, corner0_normal,
	// corner1_tangential, corner1_normal, corner2_tangential, corner2_normal,
	// corner3_tangential, corner3_normal, each 32 bits.
	output logic [319:0]  m_axis_tdata,
	// From bit 0: status[2:0].
	output logic [2:0]    m_axis_tuser
);

	localparam logic signed [34:0] ONE28 = 35'sd268435456;
	localparam logic [30:0]        ONE30 = 31'd1073741824;

	// Configuration registers. The user must change them only while the pipeline is empty; the
	// block does not enforce this. Stages 3 and 4 and the dividers read them directly.
	logic signed [31:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [15:0]        slack_q;
	logic [19:0]        tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= 32'sd0;
			x_max_q <= 32'sd65536;
			y_min_q <= 32'sd0;
			y_max_q <= 32'sd65536;
			slack_q <= 16'd0;
			tol_q   <= 20'd65536;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bpls_pkg::REG_X_MIN: x_min_q <= cfg_data;
				bpls_pkg::REG_X_MAX: x_max_q <= cfg_data;
				bpls_pkg::REG_Y_MIN: y_min_q <= cfg_data;
				bpls_pkg::REG_Y_MAX: y_max_q <= cfg_data;
				bpls_pkg::REG_SLACK: slack_q <= cfg_data[15:0];
				bpls_pkg::REG_TOL:   tol_q   <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// Rectangle spans; meaningful only when the rectangle is not degenerate.
	logic [31:0] span_x, span_y;
	logic        degenerate;
	assign span_x     = 32'(x_max_q - x_min_q);
	assign span_y     = 32'(y_max_q - y_min_q);
	assign degenerate = (x_max_q <= x_min_q) || (y_max_q <= y_min_q);

	// Stage enables: a stage loads when it is empty or its item moves on.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en1, en2, en3, en4, en5, en6, en7, en8, en9;
	logic div_in_ready, div_out_valid;

	assign en9 = !v_s9 || m_axis_tready;
	assign en8 = !v_s8 || en9;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || div_in_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= div_out_valid;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
			if (en9) v_s9 <= v_s8;
		end
	end

	// Stage 1: unpack the item and form the component products of the frame checks.
	logic signed [31:0] f_in, px_in, py_in;
	logic signed [15:0] nx_in, ny_in, tx_in, ty_in;
	assign f_in  = s_axis_tdata[31:0];
	assign nx_in = s_axis_tdata[47:32];
	assign ny_in = s_axis_tdata[63:48];
	assign tx_in = s_axis_tdata[79:64];
	assign ty_in = s_axis_tdata[95:80];
	assign px_in = s_axis_tdata[127:96];
	assign py_in = s_axis_tdata[159:128];

	logic signed [31:0] f_s1, px_s1, py_s1;
	logic signed [31:0] pnx_s1, pny_s1, ptx_s1, pty_s1, pntx_s1, pnty_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			f_s1    <= f_in;
			px_s1   <= px_in;
			py_s1   <= py_in;
			pnx_s1  <= nx_in * nx_in;
			pny_s1  <= ny_in * ny_in;
			ptx_s1  <= tx_in * tx_in;
			pty_s1  <= ty_in * ty_in;
			pntx_s1 <= nx_in * tx_in;
			pnty_s1 <= ny_in * ty_in;
		end
	end

	// Stage 2: squared norms and the dot product, exact in Q5.28.
	logic signed [31:0] f_s2, px_s2, py_s2;
	logic signed [32:0] nn_s2, tt_s2, nt_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			f_s2  <= f_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			nn_s2 <= 33'(pnx_s1) + 33'(pny_s1);
			tt_s2 <= 33'(ptx_s1) + 33'(pty_s1);
			nt_s2 <= 33'(pntx_s1) + 33'(pnty_s1);
		end
	end

	// Stage 3: the checks in priority order, then the clamped offsets into the
	// rectangle. A rejected item carries a zero force, which makes every later
	// product, and so every result field, zero.
	logic signed [34:0] tol_e, nn_e, tt_e, nt_e;
	logic signed [33:0] lo_x, hi_x, lo_y, hi_y, px_e, py_e;
	logic               outside;
	bpls_pkg::status_t  status_c;
	logic signed [31:0] cx, cy;

	always_comb begin
		tol_e   = $signed({15'd0, tol_q});
		nn_e    = 35'(nn_s2);
		tt_e    = 35'(tt_s2);
		nt_e    = 35'(nt_s2);
		lo_x    = 34'(x_min_q) - $signed({18'd0, slack_q});
		hi_x    = 34'(x_max_q) + $signed({18'd0, slack_q});
		lo_y    = 34'(y_min_q) - $signed({18'd0, slack_q});
		hi_y    = 34'(y_max_q) + $signed({18'd0, slack_q});
		px_e    = 34'(px_s2);
		py_e    = 34'(py_s2);
		outside = (px_e < lo_x) || (px_e > hi_x) || (py_e < lo_y) || (py_e > hi_y);

		priority if (f_s2 < 0) begin
			status_c = bpls_pkg::ST_NEG_FORCE;
		end else if ((nn_e > ONE28 + tol_e) || (nn_e < ONE28 - tol_e)) begin
			status_c = bpls_pkg::ST_NORMAL;
		end else if ((tt_e > ONE28 + tol_e) || (tt_e < ONE28 - tol_e)) begin
			status_c = bpls_pkg::ST_TANGENT;
		end else if ((nt_e > tol_e) || (nt_e < -tol_e)) begin
			status_c = bpls_pkg::ST_ORTHO;
		end else if (degenerate) begin
			status_c = bpls_pkg::ST_DEGENERATE;
		end else if (outside) begin
			status_c = bpls_pkg::ST_OUTSIDE;
		end else begin
			status_c = bpls_pkg::ST_OK;
		end

		priority if (px_s2 < x_min_q) begin
			cx = x_min_q;
		end else if (px_s2 > x_max_q) begin
			cx = x_max_q;
		end else begin
			cx = px_s2;
		end
		priority if (py_s2 < y_min_q) begin
			cy = y_min_q;
		end else if (py_s2 > y_max_q) begin
			cy = y_max_q;
		end else begin
			cy = py_s2;
		end
	end

	bpls_pkg::status_t  status_s3;
	logic signed [31:0] f_s3;
	logic [29:0]        nn_s3;
	logic signed [21:0] nt_s3;
	logic [31:0]        dx_s3, dy_s3;

	// On an accepted item the norm fits 30 bits and the dot product 22 bits.
	always_ff @(posedge clk) begin
		if (en3) begin
			status_s3 <= status_c;
			f_s3      <= (status_c == bpls_pkg::ST_OK) ? f_s2 : 32'sd0;
			nn_s3     <= nn_s2[29:0];
			nt_s3     <= nt_s2[21:0];
			dx_s3     <= 32'(cx - x_min_q);
			dy_s3     <= 32'(cy - y_min_q);
		end
	end

	// Stage 4: force products and the rounded division numerators.
	bpls_pkg::status_t  status_s4;
	logic signed [63:0] pt_s4, pn_s4;
	logic [63:0]        num_x_s4, num_y_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			status_s4 <= status_s3;
			pt_s4     <= 64'(f_s3) * 64'(nt_s3);
			pn_s4     <= 64'(f_s3) * $signed({34'd0, nn_s3});
			num_x_s4  <= {2'b00, dx_s3, 30'd0} + {33'd0, span_x[31:1]};
			num_y_s4  <= {2'b00, dy_s3, 30'd0} + {33'd0, span_y[31:1]};
		end
	end

	// Stage 5: totals, rounded to Q16.16 and saturated.
	bpls_pkg::div_side_t side_s5;
	logic [63:0]         num_x_s5, num_y_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			side_s5.status <= status_s4;
			side_s5.ft     <= bpls_pkg::sat32(-bpls_pkg::round28(pt_s4));
			side_s5.fn     <= bpls_pkg::sat32(-bpls_pkg::round28(pn_s4));
			num_x_s5       <= num_x_s4;
			num_y_s5       <= num_y_s4;
		end
	end

	// Fractions u and v in Q1.30.
	logic [30:0]         quo_x, quo_y;
	bpls_pkg::div_side_t side_d;

	bpls_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_in_ready),
		.in_num_x  (num_x_s5),
		.in_num_y  (num_y_s5),
		.in_side   (side_s5),
		.span_x    (span_x),
		.span_y    (span_y),
		.out_valid (div_out_valid),
		.out_ready (en6),
		.out_quo_x (quo_x),
		.out_quo_y (quo_y),
		.out_side  (side_d)
	);

	// Stage 6: split the totals along x with weight (1-u).
	bpls_pkg::status_t  status_s6;
	logic signed [31:0] ft_s6, fn_s6;
	logic signed [63:0] at_raw_s6, an_raw_s6;
	logic [30:0]        omv_s6;
	logic [30:0]        omu;
	assign omu = ONE30 - quo_x;

	always_ff @(posedge clk) begin
		if (en6) begin
			status_s6 <= side_d.status;
			ft_s6     <= side_d.ft;
			fn_s6     <= side_d.fn;
			at_raw_s6 <= 64'(side_d.ft) * $signed({33'd0, omu});
			an_raw_s6 <= 64'(side_d.fn) * $signed({33'd0, omu});
			omv_s6    <= ONE30 - quo_y;
		end
	end

	// Stage 7: x shares; the shares of one total lie between zero and that total.
	bpls_pkg::status_t  status_s7;
	logic signed [31:0] ft_s7, fn_s7, at_s7, an_s7, bt_s7, bn_s7;
	logic [30:0]        omv_s7;
	logic signed [63:0] at_r, an_r;
	assign at_r = bpls_pkg::round30(at_raw_s6);
	assign an_r = bpls_pkg::round30(an_raw_s6);

	always_ff @(posedge clk) begin
		if (en7) begin
			status_s7 <= status_s6;
			ft_s7     <= ft_s6;
			fn_s7     <= fn_s6;
			at_s7     <= at_r[31:0];
			an_s7     <= an_r[31:0];
			bt_s7     <= ft_s6 - at_r[31:0];
			bn_s7     <= fn_s6 - an_r[31:0];
			omv_s7    <= omv_s6;
		end
	end

	// Stage 8: split each x share along y with weight (1-v).
	bpls_pkg::status_t  status_s8;
	logic signed [31:0] ft_s8, fn_s8, at_s8, an_s8, bt_s8, bn_s8;
	logic signed [63:0] c0t_raw_s8, c0n_raw_s8, c1t_raw_s8, c1n_raw_s8;

	always_ff @(posedge clk) begin
		if (en8) begin
			status_s8  <= status_s7;
			ft_s8      <= ft_s7;
			fn_s8      <= fn_s7;
			at_s8      <= at_s7;
			an_s8      <= an_s7;
			bt_s8      <= bt_s7;
			bn_s8      <= bn_s7;
			c0t_raw_s8 <= 64'(at_s7) * $signed({33'd0, omv_s7});
			c0n_raw_s8 <= 64'(an_s7) * $signed({33'd0, omv_s7});
			c1t_raw_s8 <= 64'(bt_s7) * $signed({33'd0, omv_s7});
			c1n_raw_s8 <= 64'(bn_s7) * $signed({33'd0, omv_s7});
		end
	end

	// Stage 9: output register. Corners 3 and 2 take what is left of the x
	// shares, so the four corners always add up to the totals.
	bpls_pkg::status_t  status_s9;
	logic signed [31:0] ft_s9, fn_s9;
	logic signed [31:0] c0t_s9, c0n_s9, c1t_s9, c1n_s9, c2t_s9, c2n_s9, c3t_s9, c3n_s9;
	logic signed [63:0] c0t_r, c0n_r, c1t_r, c1n_r;
	assign c0t_r = bpls_pkg::round30(c0t_raw_s8);
	assign c0n_r = bpls_pkg::round30(c0n_raw_s8);
	assign c1t_r = bpls_pkg::round30(c1t_raw_s8);
	assign c1n_r = bpls_pkg::round30(c1n_raw_s8);

	always_ff @(posedge clk) begin
		if (en9) begin
			status_s9 <= status_s8;
			ft_s9     <= ft_s8;
			fn_s9     <= fn_s8;
			c0t_s9    <= c0t_r[31:0];
			c0n_s9    <= c0n_r[31:0];
			c1t_s9    <= c1t_r[31:0];
			c1n_s9    <= c1n_r[31:0];
			c3t_s9    <= at_s8 - c0t_r[31:0];
			c3n_s9    <= an_s8 - c0n_r[31:0];
			c2t_s9    <= bt_s8 - c1t_r[31:0];
			c2n_s9    <= bn_s8 - c1n_r[31:0];
		end
	end

	assign m_axis_tvalid = v_s9;
	assign m_axis_tuser  = status_s9;
	assign m_axis_tdata  = {c3n_s9, c3t_s9, c2n_s9, c2t_s9, c1n_s9, c1t_s9,
		c0n_s9, c0t_s9, fn_s9, ft_s9};

`ifndef SYNTHESIS
	// A rejected item shows nothing but its status.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (status_s9 != bpls_pkg::ST_OK)) |-> (m_axis_tdata == '0))
		else $error("rejected item carries nonzero data");

	// The corner shares add up to the totals.
	a_sum_t: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(c0t_s9 + c1t_s9 + c2t_s9 + c3t_s9) == ft_s9))
		else $error("tangential shares do not sum to the total");

	a_sum_n: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(c0n_s9 + c1n_s9 + c2n_s9 + c3n_s9) == fn_s9))
		else $error("normal shares do not sum to the total");

	// A non-negative force pushes against the normal.
	a_normal_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (fn_s9 <= 32'sd0))
		else $error("normal total is positive");
`endif

endmodule

[sim/bilinear_point_load_scatter_tb.sv]
`timescale 1ns / 1ps

module bilinear_point_load_scatter_tb;

	// One contact event as it enters the block.
	typedef struct {
		logic signed [31:0] force_mag;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic signed [31:0] px;
		logic signed [31:0] py;
	} contact_t;

	// One scatter result: status, totals and the four corner shares.
	typedef struct {
		bpls_pkg::status_t  status;
		logic signed [31:0] ft;
		logic signed [31:0] fn;
		logic signed [31:0] ct [4];
		logic signed [31:0] cn [4];
	} scatter_t;

	// One row of the directed table. When has_golden is set, the status and
	// totals typed in the row must match the predictor, which the block is checked against.
	typedef struct {
		contact_t           ev;
		bit                 has_golden;
		bpls_pkg::status_t  gold_status;
		logic signed [31:0] gold_ft;
		logic signed [31:0] gold_fn;
	} directed_row_t;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES  = 120;
	localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;
	localparam logic signed [31:0] ONE_Q16  = 32'sd65536;

	logic          clk;
	logic          arst_n;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [2:0]    cfg_index;
	logic [31:0]   cfg_data;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [159:0]  s_axis_tdata;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [319:0]  m_axis_tdata;
	logic [2:0]    m_axis_tuser;

	bilinear_point_load_scatter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Shadow copy of the element configuration, kept in step with every write.
	logic signed [31:0] x_lo, x_hi, y_lo, y_hi;
	logic [15:0]        slack;
	logic [19:0]        tol;

	scatter_t pending_scatter [$];
	int       fail_count;
	int       cycle_count;
	bit       hold_sink;
	bit       sink_stall_en;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LIMIT_CYCLES) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Rounding shift, ties away from zero.
	function automatic logic signed [63:0] rshift_round(input logic signed [63:0] v,
			input int s);
		logic [63:0] half;
		logic [63:0] mag;
		begin
			half = 64'd1 << (s - 1);
			if (v >= 0)
				return (v + half) >>> s;
			mag = -v;
			return -$signed((mag + half) >> s);
		end
	endfunction

	function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
		begin
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		end
	endfunction

	// Position of p within [lo, hi] as a Q1.30 fraction, rounded half up.
	function automatic logic signed [63:0] unit_frac(input logic signed [63:0] p,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		logic [63:0] span;
		logic [63:0] d;
		logic signed [63:0] c;
		begin
			c = (p < lo) ? lo : ((p > hi) ? hi : p);
			span = hi - lo;
			d = c - lo;
			return ((d << 30) + span / 2) / span;
		end
	endfunction

	// Bilinear split that keeps the four shares summing to the total.
	task automatic share_corners(input logic signed [63:0] f, input logic signed [63:0] u,
			input logic signed [63:0] v, output logic signed [31:0] c [4]);
		logic signed [63:0] a, b, c0, c1;
		logic signed [63:0] one30;
		begin
			one30 = 64'sd1 << 30;
			a = rshift_round(f * (one30 - u), 30);
			b = f - a;
			c0 = rshift_round(a * (one30 - v), 30);
			c1 = rshift_round(b * (one30 - v), 30);
			c[0] = c0[31:0];
			c[3] = 32'(a - c0);
			c[1] = c1[31:0];
			c[2] = 32'(b - c1);
		end
	endtask

	task automatic predict_scatter(input contact_t ev, output scatter_t r);
		logic signed [63:0] f, nn, tt, nt, dn, dt, ft, fn, u, v, one28;
		logic signed [63:0] sl;
		begin
			f = ev.force_mag;
			nn = ev.nx * ev.nx + ev.ny * ev.ny;
			tt = ev.tx * ev.tx + ev.ty * ev.ty;
			nt = ev.nx * ev.tx + ev.ny * ev.ty;
			one28 = 64'sd1 << 28;
			dn = nn - one28;
			dt = tt - one28;
			sl = $signed({48'd0, slack});
			r.status = bpls_pkg::ST_OK;
			r.ft = '0;
			r.fn = '0;
			for (int k = 0; k < 4; k++) begin
				r.ct[k] = '0;
				r.cn[k] = '0;
			end
			if (f < 0)
				r.status = bpls_pkg::ST_NEG_FORCE;
			else if ((dn < 0 ? -dn : dn) > tol)
				r.status = bpls_pkg::ST_NORMAL;
			else if ((dt < 0 ? -dt : dt) > tol)
				r.status = bpls_pkg::ST_TANGENT;
			else if ((nt < 0 ? -nt : nt) > tol)
				r.status = bpls_pkg::ST_ORTHO;
			else if (x_hi <= x_lo || y_hi <= y_lo)
				r.status = bpls_pkg::ST_DEGENERATE;
			else if (64'(ev.px) < 64'(x_lo) - sl || 64'(ev.px) > 64'(x_hi) + sl ||
					64'(ev.py) < 64'(y_lo) - sl || 64'(ev.py) > 64'(y_hi) + sl)
				r.status = bpls_pkg::ST_OUTSIDE;
			if (r.status == bpls_pkg::ST_OK) begin
				// The world force is -F*n, so both projections carry a minus sign.
				ft = clip32(rshift_round(-(f * nt), 28));
				fn = clip32(rshift_round(-(f * nn), 28));
				u = unit_frac(ev.px, x_lo, x_hi);
				v = unit_frac(ev.py, y_lo, y_hi);
				r.ft = ft[31:0];
				r.fn = fn[31:0];
				share_corners(ft, u, v, r.ct);
				share_corners(fn, u, v, r.cn);
			end
		end
	endtask

	// Present one register write; the valid stays high across consecutive writes.
	task automatic write_reg(input bpls_pkg::reg_index_t idx, input logic [31:0] val);
		begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			do @(posedge clk); while (!cfg_ready);
			case (idx)
				bpls_pkg::REG_X_MIN: x_lo = val;
				bpls_pkg::REG_X_MAX: x_hi = val;
				bpls_pkg::REG_Y_MIN: y_lo = val;
				bpls_pkg::REG_Y_MAX: y_hi = val;
				bpls_pkg::REG_SLACK: slack = val[15:0];
				bpls_pkg::REG_TOL:   tol = val[19:0];
				default: ;
			endcase
		end
	endtask

	// Wait until every result has come back, then let the pipeline empty.
	task automatic wait_drained();
		begin
			while (pending_scatter.size() != 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end
	endtask

	task automatic set_rect(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
			input logic [31:0] d, input logic [31:0] s, input logic [31:0] t);
		begin
			write_reg(bpls_pkg::REG_X_MIN, a);
			write_reg(bpls_pkg::REG_X_MAX, b);
			write_reg(bpls_pkg::REG_Y_MIN, c);
			write_reg(bpls_pkg::REG_Y_MAX, d);
			write_reg(bpls_pkg::REG_SLACK, s);
			write_reg(bpls_pkg::REG_TOL, t);
			cfg_valid <= 1'b0;
		end
	endtask

	// Offer one event; the valid stays high across back-to-back items.
	task automatic send_contact(input contact_t ev);
		scatter_t r;
		int gap;
		begin
			gap = $urandom_range(0, 3);
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= {ev.py, ev.px, ev.ty, ev.tx, ev.ny, ev.nx, ev.force_mag};
			predict_scatter(ev, r);
			do @(posedge clk); while (!s_axis_tready);
			pending_scatter.push_back(r);
		end
	endtask

	task automatic idle_source();
		begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Random unit-ish frame: mostly a rotated orthonormal pair near the unit
	// circle, sometimes perturbed, sometimes pure noise.
	function automatic contact_t random_contact();
		contact_t ev;
		real ang;
		int mode;
		begin
			mode = $urandom_range(0, 9);
			ang = $urandom_range(0, 62831) / 10000.0;
			ev.nx = 16'($rtoi($cos(ang) * 16384.0));
			ev.ny = 16'($rtoi($sin(ang) * 16384.0));
			if ($urandom_range(0, 1)) begin
				ev.tx = -ev.ny;
				ev.ty = ev.nx;
			end else begin
				ev.tx = ev.ny;
				ev.ty = -ev.nx;
			end
			if (mode == 0) begin
				ev.nx = 16'($urandom);
				ev.ny = 16'($urandom);
				ev.tx = 16'($urandom);
				ev.ty = 16'($urandom);
			end else if (mode == 1) begin
				ev.nx = ev.nx + $signed(16'($urandom_range(0, 8))) - 16'sd4;
				ev.ty = ev.ty + $signed(16'($urandom_range(0, 8))) - 16'sd4;
			end
			case ($urandom_range(0, 5))
				0: ev.force_mag = $urandom;
				1: ev.force_mag = 32'h7FFF_FFFF - $urandom_range(0, 3);
				default: ev.force_mag = $urandom_range(0, 32'h00FF_FFFF);
			endcase
			if ($urandom_range(0, 7) == 0) begin
				ev.px = $urandom;
				ev.py = $urandom;
			end else begin
				// Land around the rectangle including the slack band.
				ev.px = x_lo + $signed(32'($urandom_range(0, 32'h0003_0000))) - 32'sd65536;
				ev.py = y_lo + $signed(32'($urandom_range(0, 32'h0003_0000))) - 32'sd65536;
				if ($urandom_range(0, 3) == 0) begin
					ev.px = x_hi + $signed(32'($urandom_range(0, 4))) - 32'sd2;
					ev.py = y_hi + $signed(32'($urandom_range(0, 4))) - 32'sd2;
				end
			end
			return ev;
		end
	endfunction

	function automatic contact_t mk(input logic signed [31:0] f, input logic signed [15:0] nx,
			input logic signed [15:0] ny, input logic signed [15:0] tx,
			input logic signed [15:0] ty, input logic signed [31:0] px,
			input logic signed [31:0] py);
		contact_t ev;
		begin
			ev.force_mag = f;
			ev.nx = nx;
			ev.ny = ny;
			ev.tx = tx;
			ev.ty = ty;
			ev.px = px;
			ev.py = py;
			return ev;
		end
	endfunction

	function automatic directed_row_t row(input contact_t ev, input bit g,
			input bpls_pkg::status_t st, input logic signed [31:0] ft,
			input logic signed [31:0] fn);
		directed_row_t d;
		begin
			d.ev = ev;
			d.has_golden = g;
			d.gold_status = st;
			d.gold_ft = ft;
			d.gold_fn = fn;
			return d;
		end
	endfunction

	// Result checker: compares every accepted result with the oldest prediction.
	always @(posedge clk) begin
		scatter_t e;
		logic signed [31:0] got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_scatter.size() == 0) begin
				$error("result with nothing expected, status %0d", m_axis_tuser);
				fail_count++;
			end else begin
				e = pending_scatter.pop_front();
				if (m_axis_tuser !== e.status) begin
					$error("status expected %0d got %0d", e.status, m_axis_tuser);
					fail_count++;
				end
				if ($signed(m_axis_tdata[31:0]) !== e.ft) begin
					$error("total_tangential expected %0d got %0d", e.ft,
						$signed(m_axis_tdata[31:0]));
					fail_count++;
				end
				if ($signed(m_axis_tdata[63:32]) !== e.fn) begin
					$error("total_normal expected %0d got %0d", e.fn,
						$signed(m_axis_tdata[63:32]));
					fail_count++;
				end
				for (int k = 0; k < 4; k++) begin
					got = m_axis_tdata[64 + 64 * k +: 32];
					if (got !== e.ct[k]) begin
						$error("corner%0d_tangential expected %0d got %0d", k, e.ct[k], got);
						fail_count++;
					end
					got = m_axis_tdata[96 + 64 * k +: 32];
					if (got !== e.cn[k]) begin
						$error("corner%0d_normal expected %0d got %0d", k, e.cn[k], got);
						fail_count++;
					end
				end
			end
		end
	end

	// Receiver: random stalls per item, a long hold-off on request, and
	// stretches with no stalling at all.
	initial begin
		int wait_cycles;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_sink = 1'b0;
			end
			wait_cycles = sink_stall_en ? $urandom_range(0, 3) : 0;
			if (wait_cycles != 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		directed_row_t rows [$];
		scatter_t p;
		contact_t ev;
		fail_count = 0;
		hold_sink = 1'b0;
		sink_stall_en = 1'b1;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = bpls_pkg::REG_X_MIN;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		x_lo = 32'sd0;
		x_hi = ONE_Q16;
		y_lo = 32'sd0;
		y_hi = ONE_Q16;
		slack = 16'd0;
		tol = 20'd65536;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset rectangle [0,1] x [0,1]. With n along +y
		// the normal total is -F exactly and the tangential total is zero.
		rows.push_back(row(mk(ONE_Q16, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, 32'sd32768,
			32'sd32768), 1'b1, bpls_pkg::ST_OK, 32'sd0, -ONE_Q16));
		rows.push_back(row(mk(32'sd0, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, 32'sd0, 32'sd0),
			1'b1, bpls_pkg::ST_OK, 32'sd0, 32'sd0));
		rows.push_back(row(mk(32'sh7FFFFFFF, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, ONE_Q16,
			ONE_Q16), 1'b1, bpls_pkg::ST_OK, 32'sd0, 32'sh80000001));
		rows.push_back(row(mk(32'sh80000000, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, 32'sd0,
			32'sd0), 1'b1, bpls_pkg::ST_NEG_FORCE, 32'sd0, 32'sd0));
		rows.push_back(row(mk(-32'sd1, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, 32'sd0, 32'sd0),
			1'b1, bpls_pkg::ST_NEG_FORCE, 32'sd0, 32'sd0));
		// Zero-length normal, then zero-length tangent.
		rows.push_back(row(mk(ONE_Q16, 16'sd0, 16'sd0, UNIT_Q14, 16'sd0, 32'sd0, 32'sd0),
			1'b1, bpls_pkg::ST_NORMAL, 32'sd0, 32'sd0));
		rows.push_back(row(mk(ONE_Q16, 16'sd0, UNIT_Q14, 16'sd0, 16'sd0, 32'sd0, 32'sd0),
			1'b1, bpls_pkg::ST_TANGENT, 32'sd0, 32'sd0));
		rows.push_back(row(mk(ONE_Q16, 16'sh8000, 16'sh8000, UNIT_Q14, 16'sd0, 32'sd0,
			32'sd0), 1'b1, bpls_pkg::ST_NORMAL, 32'sd0, 32'sd0));
		rows.push_back(row(mk(ONE_Q16, UNIT_Q14, 16'sd0, 16'sh7FFF, 16'sh7FFF, 32'sd0,
			32'sd0), 1'b1, bpls_pkg::ST_TANGENT, 32'sd0, 32'sd0));
		// Parallel pair fails orthogonality.
		rows.push_back(row(mk(ONE_Q16, UNIT_Q14, 16'sd0, UNIT_Q14, 16'sd0, 32'sd0, 32'sd0),
			1'b1, bpls_pkg::ST_ORTHO, 32'sd0, 32'sd0));
		// Outside on each side, and the extreme coordinates.
		rows.push_back(row(mk(ONE_Q16, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, -32'sd1, 32'sd0),
			1'b1, bpls_pkg::ST_OUTSIDE, 32'sd0, 32'sd0));
		rows.push_back(row(mk(ONE_Q16, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, 32'sd0,
			ONE_Q16 + 32'sd1), 1'b1, bpls_pkg::ST_OUTSIDE, 32'sd0, 32'sd0));
		rows.push_back(row(mk(ONE_Q16, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, 32'sh7FFFFFFF,
			32'sd0), 1'b1, bpls_pkg::ST_OUTSIDE, 32'sd0, 32'sd0));
		rows.push_back(row(mk(ONE_Q16, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, 32'sd0,
			32'sh80000000), 1'b1, bpls_pkg::ST_OUTSIDE, 32'sd0, 32'sd0));
		// Two oblique frames and one axis frame, checked by the predictor only.
		rows.push_back(row(mk(32'sd123456, 16'sd11585, 16'sd11585, -16'sd11585, 16'sd11585,
			32'sd20000, 32'sd50000), 1'b0, bpls_pkg::ST_OK, 32'sd0, 32'sd0));
		rows.push_back(row(mk(32'sh7FFFFFFF, 16'sd11585, -16'sd11585, 16'sd11585, 16'sd11585,
			32'sd1, 32'sd65535), 1'b0, bpls_pkg::ST_OK, 32'sd0, 32'sd0));
		rows.push_back(row(mk(32'sd777, -UNIT_Q14, 16'sd0, 16'sd0, -UNIT_Q14, 32'sd12345,
			32'sd54321), 1'b0, bpls_pkg::ST_OK, 32'sd0, 32'sd0));
		foreach (rows[i]) begin
			predict_scatter(rows[i].ev, p);
			if (rows[i].has_golden) begin
				if (p.status != rows[i].gold_status) begin
					$error("table row %0d: status expected %0d got %0d", i,
						rows[i].gold_status, p.status);
					fail_count++;
				end
				if (p.ft != rows[i].gold_ft) begin
					$error("table row %0d: total_tangential expected %0d got %0d", i,
						rows[i].gold_ft, p.ft);
					fail_count++;
				end
				if (p.fn != rows[i].gold_fn) begin
					$error("table row %0d: total_normal expected %0d got %0d", i,
						rows[i].gold_fn, p.fn);
					fail_count++;
				end
			end
			send_contact(rows[i].ev);
		end
		idle_source();
		wait_drained();

		// Degenerate rectangle, then slack band clamping with extreme settings.
		set_rect(32'd65536, 32'd65536, 0, 32'd65536, 0, 32'd65536);
		send_contact(mk(ONE_Q16, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, 32'sd65536, 32'sd0));
		idle_source();
		wait_drained();
		set_rect(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF, 32'hFFFFF);
		for (int i = 0; i < 40; i++) begin
			ev = random_contact();
			ev.px = $urandom;
			ev.py = $urandom;
			send_contact(ev);
		end
		idle_source();
		wait_drained();
		set_rect(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_8000, 32'h0000_8000, 32'hFFFF, 0);
		send_contact(mk(ONE_Q16, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, 32'sh0001_8000,
			-32'sd32768));
		send_contact(mk(ONE_Q16, 16'sd0, UNIT_Q14, UNIT_Q14, 16'sd0, -32'sd131071,
			32'sd98303));

		// Long receiver hold-off while the sender keeps offering items.
		hold_sink = 1'b1;
		for (int i = 0; i < 80; i++)
			send_contact(random_contact());
		idle_source();
		wait_drained();

		// Random phases over several rectangles.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_rect(0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0000_1000, 32'd65536);
				1: set_rect(32'hFFF0_0000, 32'h0020_0000, 32'h0010_0000, 32'h0010_0003,
					32'h0000_0003, 32'd2000);
				2: set_rect(32'h1234_5678, 32'h1234_5679, 32'h8000_0000, 32'h8000_0001,
					0, 32'hFFFFF);
				3: set_rect(32'hFFFF_FFFF, 32'h7FFF_0000, 32'hFFFF_0000, 32'h0000_0007,
					32'h0000_8000, 32'd50);
				default: set_rect($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 32'hFFFFF));
			endcase
			sink_stall_en = (phase != 2);
			for (int i = 0; i < 95; i++)
				send_contact(random_contact());
			// Sender pauses until every expected result has come back.
			idle_source();
			wait_drained();
		end

		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
